@@ rtl/core/dmx_pkg.sv @@
package dmx_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS      = 24;
    localparam int COUNT_BITS       = 4;
    localparam int POSITIONS_BITS   = 24;
    localparam int CODE_BITS        = 3;
    localparam int CFG_INDEX_BITS   = 4;
    localparam int CFG_DATA_BITS    = 24;
    localparam int MAX_CHANNELS_DEF = 8;

    // weights in unsigned q1.16
    localparam int W_BITS = 17;
    localparam logic [W_BITS-1:0] W_ONE  = 17'd65536;
    localparam logic [W_BITS-1:0] W_HALF = 17'd32768;
    localparam logic [W_BITS-1:0] W_ISQ2 = 17'd46341;
    localparam logic [W_BITS-1:0] W_ZERO = 17'd0;

    // position codes
    localparam logic [CODE_BITS-1:0] POS_UNKNOWN   = 3'd0;
    localparam logic [CODE_BITS-1:0] POS_FL        = 3'd1;
    localparam logic [CODE_BITS-1:0] POS_FR        = 3'd2;
    localparam logic [CODE_BITS-1:0] POS_FC        = 3'd3;
    localparam logic [CODE_BITS-1:0] POS_LFE       = 3'd4;
    localparam logic [CODE_BITS-1:0] POS_LEFT_GRP  = 3'd5;
    localparam logic [CODE_BITS-1:0] POS_RIGHT_GRP = 3'd6;
    localparam logic [CODE_BITS-1:0] POS_CENTRE_GRP = 3'd7;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT     = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_POSITIONS = 4'd1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_word_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_0;
        logic signed [SAMPLE_BITS-1:0] sample_1;
        logic signed [SAMPLE_BITS-1:0] sample_2;
        logic signed [SAMPLE_BITS-1:0] sample_3;
        logic signed [SAMPLE_BITS-1:0] sample_4;
        logic signed [SAMPLE_BITS-1:0] sample_5;
        logic signed [SAMPLE_BITS-1:0] sample_6;
        logic signed [SAMPLE_BITS-1:0] sample_7;
    } frame_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } stereo_t;

    typedef struct packed {
        logic [W_BITS-1:0] wl;
        logic [W_BITS-1:0] wr;
    } weights_t;

    function automatic weights_t lane_weights(
        input logic [CODE_BITS-1:0] code,
        input logic                 is_first,
        input logic                 is_second
    );
        weights_t w;
        case (code)
            POS_FL:         begin w.wl = W_ONE;  w.wr = W_ZERO; end
            POS_FR:         begin w.wl = W_ZERO; w.wr = W_ONE;  end
            POS_FC:         begin w.wl = W_ISQ2; w.wr = W_ISQ2; end
            POS_LFE:        begin w.wl = W_ZERO; w.wr = W_ZERO; end
            POS_LEFT_GRP:   begin w.wl = W_ISQ2; w.wr = W_ZERO; end
            POS_RIGHT_GRP:  begin w.wl = W_ZERO; w.wr = W_ISQ2; end
            POS_CENTRE_GRP: begin w.wl = W_ISQ2; w.wr = W_ISQ2; end
            default:
            begin
                // unknown position falls back on the channel index
                if (is_first)
                begin
                    w.wl = W_ONE;
                    w.wr = W_ZERO;
                end
                else if (is_second)
                begin
                    w.wl = W_ZERO;
                    w.wr = W_ONE;
                end
                else
                begin
                    w.wl = W_HALF;
                    w.wr = W_HALF;
                end
            end
        endcase
        return w;
    endfunction

    function automatic sample_word_t frame_sample(
        input frame_t         f,
        input logic [2:0]     idx
    );
        sample_word_t s;
        case (idx)
            3'd1:    s = f.sample_1;
            3'd2:    s = f.sample_2;
            3'd3:    s = f.sample_3;
            3'd4:    s = f.sample_4;
            3'd5:    s = f.sample_5;
            3'd6:    s = f.sample_6;
            3'd7:    s = f.sample_7;
            default: s = f.sample_0;
        endcase
        return s;
    endfunction

endpackage

@@ rtl/core/multichannel_downmix_to_stereo.sv @@
// path: a frame transaction reaches its stereo transaction through the multiply stage,
//   the adder tree, the rounding stage, the one-bit-per-stage divider and the output register
// throughput: one frame per cycle; a held result freezes the whole pipeline until taken
// reset: rst_n is asynchronous and active low; channel count returns to two (pass-through),
//   position codes to zero, and every pipeline valid bit is cleared
module multichannel_downmix_to_stereo #(
    parameter int MAX_CHANNELS = dmx_pkg::MAX_CHANNELS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // frame channel
    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  dmx_pkg::frame_t                       sample,
    // stereo channel
    output logic                                  mix_valid,
    input  logic                                  mix_ready,
    output dmx_pkg::stereo_t                      mix,
    // register write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dmx_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [dmx_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import dmx_pkg::*;

    localparam int CH_BITS   = $clog2(MAX_CHANNELS);
    localparam int TOT_BITS  = W_BITS + CH_BITS;
    localparam int ACC_BITS  = SAMPLE_BITS + TOT_BITS;
    localparam int PROD_BITS = SAMPLE_BITS + W_BITS;
    // lane stage, tree levels, rounding stage, divider stages
    localparam int LAT       = 2 + CH_BITS + SAMPLE_BITS;

    // configuration registers; the user must write them only while the block is idle, the block has no check for it
    logic [COUNT_BITS-1:0]     count_reg;
    logic [POSITIONS_BITS-1:0] pos_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_BITS'(2);
            pos_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CHANNEL_COUNT:     count_reg <= cfg_data[COUNT_BITS-1:0];
                REG_CHANNEL_POSITIONS: pos_reg   <= cfg_data[POSITIONS_BITS-1:0];
                default:               ;
            endcase
        end
    end

    // whole pipeline moves together; it stops only while a result waits
    logic en;
    logic mix_valid_reg;

    assign en           = !mix_valid_reg || mix_ready;
    assign sample_ready = en;

    // channel count clipped to the lane count
    logic [COUNT_BITS-1:0] n_eff;
    logic                  pass;

    always_comb
    begin
        n_eff = (count_reg > COUNT_BITS'(MAX_CHANNELS)) ? COUNT_BITS'(MAX_CHANNELS) : count_reg;
        pass  = (n_eff == COUNT_BITS'(2));
    end

    // one lane per channel: weight lookup and the two weighted products
    logic signed [PROD_BITS-1:0] prod_l [MAX_CHANNELS];
    logic signed [PROD_BITS-1:0] prod_r [MAX_CHANNELS];
    weights_t                    weights [MAX_CHANNELS];

    genvar c;
    generate
        for (c = 0; c < MAX_CHANNELS; c++)
        begin : g_lane
            dmx_lane #(
                .LANE_IDX (c)
            ) u_lane (
                .clk     (clk),
                .en      (en),
                .sample  (frame_sample(sample, 3'(c))),
                .code    (pos_reg[CODE_BITS*c +: CODE_BITS]),
                .active  (COUNT_BITS'(c) < n_eff),
                .prod_l  (prod_l[c]),
                .prod_r  (prod_r[c]),
                .weights (weights[c])
            );
        end
    endgenerate

    // adder tree across the lanes and rounding offset
    logic [ACC_BITS-1:0] num_l, num_r;
    logic [TOT_BITS-1:0] den_l, den_r;
    logic                neg_l, neg_r;

    dmx_merge #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_merge (
        .clk     (clk),
        .en      (en),
        .prod_l  (prod_l),
        .prod_r  (prod_r),
        .weights (weights),
        .num_l   (num_l),
        .den_l   (den_l),
        .neg_l   (neg_l),
        .num_r   (num_r),
        .den_r   (den_r),
        .neg_r   (neg_r)
    );

    // normalising division, one per side
    logic [SAMPLE_BITS-1:0] quo_l, quo_r;
    logic                   qneg_l, qneg_r;

    dmx_div #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_div_l (
        .clk     (clk),
        .en      (en),
        .num     (num_l),
        .den     (den_l),
        .neg     (neg_l),
        .quo     (quo_l),
        .quo_neg (qneg_l)
    );

    dmx_div #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_div_r (
        .clk     (clk),
        .en      (en),
        .num     (num_r),
        .den     (den_r),
        .neg     (neg_r),
        .quo     (quo_r),
        .quo_neg (qneg_r)
    );

    // side line: transaction valid, pass-through flag and the two raw samples
    logic         side_valid_reg [LAT];
    logic         side_pass_reg  [LAT];
    sample_word_t side_s0_reg    [LAT];
    sample_word_t side_s1_reg    [LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                side_valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            side_valid_reg[0] <= sample_valid;
            for (int i = 1; i < LAT; i++)
            begin
                side_valid_reg[i] <= side_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_pass_reg[0] <= pass;
            side_s0_reg[0]   <= sample.sample_0;
            side_s1_reg[0]   <= sample.sample_1;
            for (int i = 1; i < LAT; i++)
            begin
                side_pass_reg[i] <= side_pass_reg[i-1];
                side_s0_reg[i]   <= side_s0_reg[i-1];
                side_s1_reg[i]   <= side_s1_reg[i-1];
            end
        end
    end

    // sign and saturation; the quotient never exceeds half the sample range
    function automatic sample_word_t signed_sat(
        input logic [SAMPLE_BITS-1:0] q,
        input logic                   negative
    );
        logic [SAMPLE_BITS-1:0] max_pos;
        sample_word_t           r;
        max_pos = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        if (negative)
        begin
            r = sample_word_t'(-q);
        end
        else if (q > max_pos)
        begin
            r = sample_word_t'(max_pos);
        end
        else
        begin
            r = sample_word_t'(q);
        end
        return r;
    endfunction

    stereo_t mix_next;
    stereo_t mix_reg;

    always_comb
    begin
        if (side_pass_reg[LAT-1])
        begin
            mix_next.left_out  = side_s0_reg[LAT-1];
            mix_next.right_out = side_s1_reg[LAT-1];
        end
        else
        begin
            mix_next.left_out  = signed_sat(quo_l, qneg_l);
            mix_next.right_out = signed_sat(quo_r, qneg_r);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mix_valid_reg <= side_valid_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mix_reg <= mix_next;
        end
    end

    assign mix_valid = mix_valid_reg;
    assign mix       = mix_reg;

endmodule

@@ rtl/core/dmx_lane.sv @@
module dmx_lane #(
    parameter int LANE_IDX = 0
) (
    input  logic                                       clk,
    input  logic                                       en,
    input  logic signed [dmx_pkg::SAMPLE_BITS-1:0]     sample,
    input  logic [dmx_pkg::CODE_BITS-1:0]              code,
    input  logic                                       active,
    output logic signed [dmx_pkg::SAMPLE_BITS+dmx_pkg::W_BITS-1:0] prod_l,
    output logic signed [dmx_pkg::SAMPLE_BITS+dmx_pkg::W_BITS-1:0] prod_r,
    output dmx_pkg::weights_t                          weights
);
    import dmx_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + W_BITS;

    weights_t                       w_next;
    logic signed [PROD_BITS:0]      full_l;
    logic signed [PROD_BITS:0]      full_r;
    logic signed [PROD_BITS-1:0]    prod_l_reg;
    logic signed [PROD_BITS-1:0]    prod_r_reg;
    weights_t                       w_reg;

    always_comb
    begin
        w_next = lane_weights(code, LANE_IDX == 0, LANE_IDX == 1);
        // channels beyond the count carry no weight
        if (!active)
        begin
            w_next.wl = W_ZERO;
            w_next.wr = W_ZERO;
        end
        full_l = sample * $signed({1'b0, w_next.wl});
        full_r = sample * $signed({1'b0, w_next.wr});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_l_reg <= full_l[PROD_BITS-1:0];
            prod_r_reg <= full_r[PROD_BITS-1:0];
            w_reg      <= w_next;
        end
    end

    assign prod_l  = prod_l_reg;
    assign prod_r  = prod_r_reg;
    assign weights = w_reg;

endmodule

@@ rtl/core/dmx_merge.sv @@
module dmx_merge #(
    parameter int MAX_CHANNELS = dmx_pkg::MAX_CHANNELS_DEF,
    localparam int CH_BITS   = $clog2(MAX_CHANNELS),
    localparam int TOT_BITS  = dmx_pkg::W_BITS + CH_BITS,
    localparam int ACC_BITS  = dmx_pkg::SAMPLE_BITS + TOT_BITS,
    localparam int PROD_BITS = dmx_pkg::SAMPLE_BITS + dmx_pkg::W_BITS
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [PROD_BITS-1:0] prod_l [MAX_CHANNELS],
    input  logic signed [PROD_BITS-1:0] prod_r [MAX_CHANNELS],
    input  dmx_pkg::weights_t           weights [MAX_CHANNELS],
    output logic [ACC_BITS-1:0]         num_l,
    output logic [TOT_BITS-1:0]         den_l,
    output logic                        neg_l,
    output logic [ACC_BITS-1:0]         num_r,
    output logic [TOT_BITS-1:0]         den_r,
    output logic                        neg_r
);
    import dmx_pkg::*;

    localparam int LEAVES = 1 << CH_BITS;

    logic signed [ACC_BITS-1:0] leaf_acc_l [LEAVES];
    logic signed [ACC_BITS-1:0] leaf_acc_r [LEAVES];
    logic [TOT_BITS-1:0]        leaf_tot_l [LEAVES];
    logic [TOT_BITS-1:0]        leaf_tot_r [LEAVES];

    // heap ordered adder tree, node 1 is the root
    logic signed [ACC_BITS-1:0] node_acc_l_reg [1:LEAVES-1];
    logic signed [ACC_BITS-1:0] node_acc_r_reg [1:LEAVES-1];
    logic [TOT_BITS-1:0]        node_tot_l_reg [1:LEAVES-1];
    logic [TOT_BITS-1:0]        node_tot_r_reg [1:LEAVES-1];

    logic [ACC_BITS-1:0] num_l_reg, num_r_reg;
    logic [TOT_BITS-1:0] den_l_reg, den_r_reg;
    logic                neg_l_reg, neg_r_reg;

    genvar g;
    generate
        for (g = 0; g < LEAVES; g++)
        begin : g_leaf
            if (g < MAX_CHANNELS)
            begin : g_used
                assign leaf_acc_l[g] = ACC_BITS'(prod_l[g]);
                assign leaf_acc_r[g] = ACC_BITS'(prod_r[g]);
                assign leaf_tot_l[g] = TOT_BITS'(weights[g].wl);
                assign leaf_tot_r[g] = TOT_BITS'(weights[g].wr);
            end
            else
            begin : g_pad
                assign leaf_acc_l[g] = '0;
                assign leaf_acc_r[g] = '0;
                assign leaf_tot_l[g] = '0;
                assign leaf_tot_r[g] = '0;
            end
        end

        for (g = 1; g < LEAVES; g++)
        begin : g_node
            logic signed [ACC_BITS-1:0] a_l, b_l, a_r, b_r;
            logic [TOT_BITS-1:0]        c_l, d_l, c_r, d_r;
            if (2 * g >= LEAVES)
            begin : g_from_leaf
                assign a_l = leaf_acc_l[2*g-LEAVES];
                assign b_l = leaf_acc_l[2*g+1-LEAVES];
                assign a_r = leaf_acc_r[2*g-LEAVES];
                assign b_r = leaf_acc_r[2*g+1-LEAVES];
                assign c_l = leaf_tot_l[2*g-LEAVES];
                assign d_l = leaf_tot_l[2*g+1-LEAVES];
                assign c_r = leaf_tot_r[2*g-LEAVES];
                assign d_r = leaf_tot_r[2*g+1-LEAVES];
            end
            else
            begin : g_from_node
                assign a_l = node_acc_l_reg[2*g];
                assign b_l = node_acc_l_reg[2*g+1];
                assign a_r = node_acc_r_reg[2*g];
                assign b_r = node_acc_r_reg[2*g+1];
                assign c_l = node_tot_l_reg[2*g];
                assign d_l = node_tot_l_reg[2*g+1];
                assign c_r = node_tot_r_reg[2*g];
                assign d_r = node_tot_r_reg[2*g+1];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    node_acc_l_reg[g] <= a_l + b_l;
                    node_acc_r_reg[g] <= a_r + b_r;
                    node_tot_l_reg[g] <= c_l + d_l;
                    node_tot_r_reg[g] <= c_r + d_r;
                end
            end
        end
    endgenerate

    // sign and magnitude, divisor pick and half-divisor rounding offset
    logic [ACC_BITS-1:0] mag_l, mag_r;
    logic [TOT_BITS-1:0] den_l_next, den_r_next;

    always_comb
    begin
        mag_l = node_acc_l_reg[1][ACC_BITS-1] ? ACC_BITS'(-node_acc_l_reg[1])
                                              : ACC_BITS'(node_acc_l_reg[1]);
        mag_r = node_acc_r_reg[1][ACC_BITS-1] ? ACC_BITS'(-node_acc_r_reg[1])
                                              : ACC_BITS'(node_acc_r_reg[1]);
        den_l_next = (node_tot_l_reg[1] == '0) ? TOT_BITS'(W_ONE) : node_tot_l_reg[1];
        den_r_next = (node_tot_r_reg[1] == '0) ? TOT_BITS'(W_ONE) : node_tot_r_reg[1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_l_reg <= mag_l + ACC_BITS'(den_l_next >> 1);
            num_r_reg <= mag_r + ACC_BITS'(den_r_next >> 1);
            den_l_reg <= den_l_next;
            den_r_reg <= den_r_next;
            neg_l_reg <= node_acc_l_reg[1][ACC_BITS-1];
            neg_r_reg <= node_acc_r_reg[1][ACC_BITS-1];
        end
    end

    assign num_l = num_l_reg;
    assign num_r = num_r_reg;
    assign den_l = den_l_reg;
    assign den_r = den_r_reg;
    assign neg_l = neg_l_reg;
    assign neg_r = neg_r_reg;

endmodule

@@ rtl/core/dmx_div.sv @@
module dmx_div #(
    parameter int MAX_CHANNELS = dmx_pkg::MAX_CHANNELS_DEF,
    localparam int CH_BITS  = $clog2(MAX_CHANNELS),
    localparam int TOT_BITS = dmx_pkg::W_BITS + CH_BITS,
    localparam int ACC_BITS = dmx_pkg::SAMPLE_BITS + TOT_BITS,
    localparam int QB       = dmx_pkg::SAMPLE_BITS
) (
    input  logic                clk,
    input  logic                en,
    input  logic [ACC_BITS-1:0] num,
    input  logic [TOT_BITS-1:0] den,
    input  logic                neg,
    output logic [QB-1:0]       quo,
    output logic                quo_neg
);
    import dmx_pkg::*;

    // one quotient bit per stage; the weighted average keeps the quotient
    // below 2**QB so the top bits of the numerator start below the divisor
    logic [TOT_BITS-1:0] rem_reg [QB];
    logic [QB-1:0]       low_reg [QB];
    logic [QB-1:0]       quo_reg [QB];
    logic [TOT_BITS-1:0] den_reg [QB];
    logic                neg_reg [QB];

    genvar k;
    generate
        for (k = 0; k < QB; k++)
        begin : g_stage
            logic [TOT_BITS-1:0] src_rem;
            logic [QB-1:0]       src_low;
            logic [QB-1:0]       src_quo;
            logic [TOT_BITS-1:0] src_den;
            logic                src_neg;
            logic [TOT_BITS:0]   trial;
            logic [TOT_BITS:0]   diff;
            logic                ge;
            logic [TOT_BITS-1:0] rem_next;

            if (k == 0)
            begin : g_first
                assign src_rem = num[ACC_BITS-1:QB];
                assign src_low = num[QB-1:0];
                assign src_quo = '0;
                assign src_den = den;
                assign src_neg = neg;
            end
            else
            begin : g_rest
                assign src_rem = rem_reg[k-1];
                assign src_low = low_reg[k-1];
                assign src_quo = quo_reg[k-1];
                assign src_den = den_reg[k-1];
                assign src_neg = neg_reg[k-1];
            end

            always_comb
            begin
                trial    = {src_rem, src_low[QB-1]};
                diff     = trial - {1'b0, src_den};
                ge       = (trial >= {1'b0, src_den});
                rem_next = ge ? diff[TOT_BITS-1:0] : trial[TOT_BITS-1:0];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    low_reg[k] <= {src_low[QB-2:0], 1'b0};
                    quo_reg[k] <= {src_quo[QB-2:0], ge};
                    den_reg[k] <= src_den;
                    neg_reg[k] <= src_neg;
                end
            end
        end
    endgenerate

    assign quo     = quo_reg[QB-1];
    assign quo_neg = neg_reg[QB-1];

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import dmx_pkg::*;

    // cycles with no transaction on any channel before the run is abandoned
    localparam int IDLE_LIMIT    = 5000;
    // settle time at the end, longer than the pipeline is deep
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_FRAMES  = 102;

    localparam sample_word_t S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_word_t S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // frame channel
    logic sample_valid = 1'b0;
    logic sample_ready;
    frame_t sample = '0;

    // stereo channel
    logic mix_valid;
    logic mix_ready = 1'b0;
    stereo_t mix;

    // register write channel
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // local copy of the register file, starting from its reset values
    logic [COUNT_BITS-1:0] mix_count = 4'd2;
    logic [POSITIONS_BITS-1:0] mix_positions = '0;

    // frames waiting to be sent and stereo pairs waiting to come back
    frame_t frame_queue[$];
    stereo_t expected_mix[$];
    stereo_t want_mix;

    // idling percentages of the current phase
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned phase_no = 0;

    int mismatch_count = 0;
    int idle_cycles = 0;

    multichannel_downmix_to_stereo #(
        .MAX_CHANNELS (MAX_CHANNELS_DEF)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .mix_valid    (mix_valid),
        .mix_ready    (mix_ready),
        .mix          (mix),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // rounds acc / tot to nearest, ties away from zero
    function automatic longint div_nearest(input longint acc, input longint tot);
        longint mag;
        longint q;
        mag = (acc < 0) ? -acc : acc;
        q = (mag + tot / 2) / tot;
        return (acc < 0) ? -q : q;
    endfunction

    // clamps to the signed sample range
    function automatic sample_word_t clamp_sample(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
        return v[SAMPLE_BITS-1:0];
    endfunction

    // expected stereo pair for one frame under the given register values
    function automatic stereo_t predict_mix(
        input frame_t                    f,
        input logic [COUNT_BITS-1:0]     count,
        input logic [POSITIONS_BITS-1:0] positions
    );
        int unsigned lanes;
        int unsigned c;
        longint acc_l;
        longint acc_r;
        longint tot_l;
        longint tot_r;
        longint wl;
        longint wr;
        longint s;
        logic [CODE_BITS-1:0] code;
        stereo_t res;

        // counts above the channel maximum saturate
        lanes = (count > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF : count;

        // two channels: straight pass-through, codes ignored
        if (lanes == 2)
        begin
            res.left_out = f.sample_0;
            res.right_out = f.sample_1;
            return res;
        end

        acc_l = 0;
        acc_r = 0;
        tot_l = 0;
        tot_r = 0;
        for (c = 0; c < lanes; c++)
        begin
            // sample_0 sits in the top bits of the packed frame
            s = $signed(f[(MAX_CHANNELS_DEF - 1 - c) * SAMPLE_BITS +: SAMPLE_BITS]);
            code = positions[c * CODE_BITS +: CODE_BITS];
            case (code)
                POS_FL:         begin wl = W_ONE;  wr = W_ZERO; end
                POS_FR:         begin wl = W_ZERO; wr = W_ONE;  end
                POS_FC:         begin wl = W_ISQ2; wr = W_ISQ2; end
                POS_LFE:        begin wl = W_ZERO; wr = W_ZERO; end
                POS_LEFT_GRP:   begin wl = W_ISQ2; wr = W_ZERO; end
                POS_RIGHT_GRP:  begin wl = W_ZERO; wr = W_ISQ2; end
                POS_CENTRE_GRP: begin wl = W_ISQ2; wr = W_ISQ2; end
                default:
                begin
                    // unknown position: fall back on the channel index
                    if (c == 0)
                    begin
                        wl = W_ONE;
                        wr = W_ZERO;
                    end
                    else if (c == 1)
                    begin
                        wl = W_ZERO;
                        wr = W_ONE;
                    end
                    else
                    begin
                        wl = W_HALF;
                        wr = W_HALF;
                    end
                end
            endcase
            acc_l += s * wl;
            acc_r += s * wr;
            tot_l += wl;
            tot_r += wr;
        end

        // a side with no weight is divided by unity, its sum being zero anyway
        res.left_out = clamp_sample(div_nearest(acc_l, (tot_l > 0) ? tot_l : longint'(W_ONE)));
        res.right_out = clamp_sample(div_nearest(acc_r, (tot_r > 0) ? tot_r : longint'(W_ONE)));
        return res;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------
    // frame driver: one transaction per handshake, fed from frame_queue
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample <= '0;
        end
        else
        begin
            // predict at the accepting edge, with the registers as they stand
            if (sample_valid && sample_ready)
                expected_mix.push_back(predict_mix(sample, mix_count, mix_positions));

            // the slot frees up when nothing is held or the held frame is taken
            if (!sample_valid || sample_ready)
            begin
                if (frame_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    sample_valid <= 1'b1;
                    sample <= frame_queue.pop_front();
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // stereo monitor: compares each transaction against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mix_ready <= 1'b0;
        else
        begin
            if (mix_valid && mix_ready)
            begin
                if (expected_mix.size() == 0)
                    report_mismatch($sformatf("unexpected stereo transaction L=%0d R=%0d",
                                              mix.left_out, mix.right_out));
                else
                begin
                    want_mix = expected_mix.pop_front();
                    if (mix.left_out !== want_mix.left_out)
                        report_mismatch($sformatf("left_out got %0d want %0d",
                                                  mix.left_out, want_mix.left_out));
                    if (mix.right_out !== want_mix.right_out)
                        report_mismatch($sformatf("right_out got %0d want %0d",
                                                  mix.right_out, want_mix.right_out));
                end
            end
            // random back-pressure
            mix_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // watchdog: any transaction on any channel clears it
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && sample_ready) || (mix_valid && mix_ready)
                || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // register write, held until the handshake completes
    task automatic write_reg(
        input logic [CFG_INDEX_BITS-1:0] idx,
        input logic [CFG_DATA_BITS-1:0]  data
    );
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_CHANNEL_COUNT)
            mix_count = data[COUNT_BITS-1:0];
        else
            mix_positions = data[POSITIONS_BITS-1:0];
    endtask

    // sender holds off until every frame has been sent and every pair has come back;
    // checked on the falling edge so the rising-edge blocks have all settled
    task automatic wait_mix_drained();
        @(negedge clk);
        while (frame_queue.size() != 0 || sample_valid || expected_mix.size() != 0)
            @(negedge clk);
    endtask

    // new phase: drain, reprogram both registers, move to the next idling pattern
    task automatic set_up_phase(
        input logic [COUNT_BITS-1:0]     count,
        input logic [POSITIONS_BITS-1:0] positions
    );
        wait_mix_drained();
        write_reg(REG_CHANNEL_COUNT, CFG_DATA_BITS'(count));
        write_reg(REG_CHANNEL_POSITIONS, positions);
        phase_no++;
        case (phase_no % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 84; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 84; end
            default: begin send_idle_pct = 36; stall_pct = 36; end
        endcase
    endtask

    // full scale positive, full scale negative, then alternating by channel
    task automatic push_extreme_frames();
        frame_t fr;
        int k;
        fr = '0;
        for (k = 0; k < MAX_CHANNELS_DEF; k++)
            fr[k * SAMPLE_BITS +: SAMPLE_BITS] = S_MAX;
        frame_queue.push_back(fr);
        for (k = 0; k < MAX_CHANNELS_DEF; k++)
            fr[k * SAMPLE_BITS +: SAMPLE_BITS] = S_MIN;
        frame_queue.push_back(fr);
        for (k = 0; k < MAX_CHANNELS_DEF; k++)
            fr[k * SAMPLE_BITS +: SAMPLE_BITS] = k[0] ? S_MIN : S_MAX;
        frame_queue.push_back(fr);
    endtask

    // mostly full-range samples, with extremes and small values mixed in
    function automatic sample_word_t pick_sample();
        case ($urandom_range(0, 11))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3:       return '1;
            4:       return sample_word_t'($urandom_range(0, 6)) - sample_word_t'(3);
            default: return sample_word_t'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int p;
        int k;
        int n;
        frame_t fr;
        logic [COUNT_BITS-1:0] count_pick;
        logic [POSITIONS_BITS-1:0] pos_pick;
        logic [CODE_BITS-1:0] code_pick;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset values give pass-through
        push_extreme_frames();

        // every position code, one per channel
        set_up_phase(4'd8, {POS_CENTRE_GRP, POS_RIGHT_GRP, POS_LEFT_GRP, POS_LFE,
                            POS_FC, POS_FR, POS_FL, POS_UNKNOWN});
        push_extreme_frames();

        // single channel with an unknown code: left only
        set_up_phase(4'd1, {8{POS_UNKNOWN}});
        push_extreme_frames();

        // no channel in use
        set_up_phase(4'd0, 24'h5A_C3_96);
        push_extreme_frames();

        // count above the maximum, all centre group
        set_up_phase(4'd15, {8{POS_CENTRE_GRP}});
        push_extreme_frames();

        // nothing but low-frequency: both sides carry no weight
        set_up_phase(4'd8, {8{POS_LFE}});
        push_extreme_frames();

        // unknown fallback for the first three channels
        set_up_phase(4'd3, {8{POS_UNKNOWN}});
        push_extreme_frames();

        // random phases, each with its own register values and idling pattern
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            if ($urandom_range(0, 4) != 0)
                count_pick = COUNT_BITS'($urandom_range(1, MAX_CHANNELS_DEF));
            else
                count_pick = COUNT_BITS'($urandom_range(0, 15));
            code_pick = CODE_BITS'($urandom_range(0, 7));
            case ($urandom_range(0, 5))
                0:       pos_pick = '0;
                1:       pos_pick = '1;
                2:       pos_pick = {8{code_pick}};
                default: pos_pick = POSITIONS_BITS'($urandom());
            endcase
            set_up_phase(count_pick, pos_pick);

            for (n = 0; n < PHASE_FRAMES; n++)
            begin
                for (k = 0; k < MAX_CHANNELS_DEF; k++)
                    fr[k * SAMPLE_BITS +: SAMPLE_BITS] = pick_sample();
                frame_queue.push_back(fr);
            end
        end

        // everything back, then let the pipeline settle before the verdict
        wait_mix_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ multichannel_downmix_to_stereo.f @@
rtl/core/dmx_pkg.sv
rtl/core/dmx_lane.sv
rtl/core/dmx_merge.sv
rtl/core/dmx_div.sv
rtl/core/multichannel_downmix_to_stereo.sv
dv/tb_top.sv
